// ===== hdl/uvwc_pkg.sv =====
// Package for the distinct-value table with occurrence counts.
// Holds sizes, field codes and the controller/datapath command and status structs.
// No dependencies.
package uvwc_pkg;

  localparam int MAX_UNIQUE  = 32;
  localparam int STORE_DEPTH = 32;
  localparam int CAPACITY    = (MAX_UNIQUE > STORE_DEPTH) ? STORE_DEPTH : MAX_UNIQUE;

  localparam int ELEM_W   = 32;
  localparam int OCC_W    = 32;
  localparam int POS_W    = 5;
  localparam int TOTAL_W  = 6;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = $clog2(STORE_DEPTH);
  localparam int OUT_DATA_BITS = POS_W + ELEM_W + OCC_W + TOTAL_W;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [KIND_W-1:0] KIND_POSITION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

  localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
    logic rd_issue;
    logic rd_emit;
    logic empty_emit;
  } cmd_t;

  typedef struct packed {
    logic used_zero;
    logic out_free;
    logic rd_last;
  } stat_t;

endpackage

// ===== hdl/unique_values_with_counts.sv =====
// Top level of the distinct-value table with occurrence counts.
// Joins uvwc_ctrl and uvwc_dpath and packs the stream ports; depends on uvwc_pkg.

// A push transaction (tuser 0) returns the position of its element in a
// first-appearance table of up to 32 distinct values, or an overflow result
// when the table is full; a finish transaction (tuser 1) returns one entry
// per distinct value with its count, tlast on the final one, then empties
// the table. A push passes from acceptance through capture, then the
// parallel compare against all stored values with the registered read of
// the count memory, then the write-back of the new count with the load of
// the result register. A finish captures and then reads out one entry at a
// time, since the count memory has a single read port; a finish on an empty
// table returns one empty result. Input is taken again as soon as the last
// result of an item sits in the output register; a stalled output holds the
// commit and each readout until the result register is free.
module unique_values_with_counts (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,  // [31:0] element
  input  logic [0:0]                        in_tuser,  // [0] operation
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [4:0] position, [36:5] unique_value, [68:37] occurrences,
  // [74:69] distinct_total, [79:75] zero
  output logic [uvwc_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [1:0]                        out_tuser, // [1:0] kind
  output logic                              out_tlast
);

  uvwc_pkg::cmd_t  cmd;
  uvwc_pkg::stat_t stat;

  logic [uvwc_pkg::KIND_W-1:0]  res_kind;
  logic [uvwc_pkg::POS_W-1:0]   res_pos;
  logic [uvwc_pkg::ELEM_W-1:0]  res_value;
  logic [uvwc_pkg::OCC_W-1:0]   res_occ;
  logic [uvwc_pkg::TOTAL_W-1:0] res_total;

  uvwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser[0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  uvwc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_elem   (in_tdata),
    .out_ready (out_tready),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_kind  (res_kind),
    .out_pos   (res_pos),
    .out_value (res_value),
    .out_occ   (res_occ),
    .out_total (res_total),
    .out_last  (out_tlast)
  );

  assign out_tdata = uvwc_pkg::OUT_DATA_W'({res_total, res_occ, res_value, res_pos});
  assign out_tuser = res_kind;

endmodule

// ===== hdl/uvwc_ctrl.sv =====
// Controller state machine for the distinct-value table.
// Sequences push lookups, commits and finish readouts; depends on uvwc_pkg.
module uvwc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic           in_op,
  input  uvwc_pkg::stat_t stat,
  output uvwc_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_RDISS  = 3'd3;
  localparam logic [2:0] S_RDOUT  = 3'd4;
  localparam logic [2:0] S_EMPTY  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          if (in_op == uvwc_pkg::OP_PUSH) begin
            state_nxt = S_LOOK;
          end else if (stat.used_zero) begin
            state_nxt = S_EMPTY;
          end else begin
            state_nxt = S_RDISS;
          end
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_RDISS: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RDOUT;
      end
      S_RDOUT: begin
        if (stat.out_free) begin
          cmd.rd_emit = 1'b1;
          state_nxt   = stat.rd_last ? S_IDLE : S_RDISS;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.empty_emit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/uvwc_dpath.sv =====
// Datapath for the distinct-value table: value lanes with parallel compare,
// count memory, readout index and result register. Depends on uvwc_pkg.
module uvwc_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  uvwc_pkg::cmd_t                  cmd,
  input  logic [uvwc_pkg::ELEM_W-1:0]     in_elem,
  input  logic                            out_ready,
  output uvwc_pkg::stat_t                 stat,
  output logic                            out_valid,
  output logic [uvwc_pkg::KIND_W-1:0]     out_kind,
  output logic [uvwc_pkg::POS_W-1:0]      out_pos,
  output logic [uvwc_pkg::ELEM_W-1:0]     out_value,
  output logic [uvwc_pkg::OCC_W-1:0]      out_occ,
  output logic [uvwc_pkg::TOTAL_W-1:0]    out_total,
  output logic                            out_last
);

  localparam int IDX_W   = uvwc_pkg::IDX_W;
  localparam int TOTAL_W = uvwc_pkg::TOTAL_W;
  localparam int ELEM_W  = uvwc_pkg::ELEM_W;
  localparam int OCC_W   = uvwc_pkg::OCC_W;
  localparam int DEPTH   = uvwc_pkg::STORE_DEPTH;
  localparam logic [TOTAL_W-1:0] CAP_TOTAL = TOTAL_W'(uvwc_pkg::CAPACITY);

  logic [ELEM_W-1:0] lane_r [DEPTH];
  logic [OCC_W-1:0]  cnt_mem [DEPTH];

  logic [ELEM_W-1:0]  elem_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [OCC_W-1:0]   cnt_q_r;
  logic [ELEM_W-1:0]  val_q_r;
  logic [TOTAL_W-1:0] used_r;
  logic [IDX_W-1:0]   rd_idx_r;

  logic               out_valid_r;
  logic [uvwc_pkg::KIND_W-1:0] out_kind_r;
  logic [uvwc_pkg::POS_W-1:0]  out_pos_r;
  logic [ELEM_W-1:0]  out_value_r;
  logic [OCC_W-1:0]   out_occ_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic               out_last_r;

  logic [DEPTH-1:0]   match;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [OCC_W-1:0]   mem_wd;
  logic [OCC_W-1:0]   cnt_inc;
  logic               full;
  logic               is_new;
  logic [IDX_W-1:0]   new_idx;
  logic [TOTAL_W-1:0] rd_next;

  // Stored values are distinct, so at most one lane matches and an OR
  // of the matching lane numbers gives its index.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (TOTAL_W'(i) < used_r) && (lane_r[i] == elem_r);
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
    hit = |match;
  end

  assign full    = (used_r >= CAP_TOTAL);
  assign is_new  = !hit_r && !full;
  assign new_idx = used_r[IDX_W-1:0];
  assign cnt_inc = (cnt_q_r == uvwc_pkg::OCC_MAX) ? cnt_q_r : cnt_q_r + OCC_W'(1);
  assign rd_addr = cmd.lookup ? hit_idx : rd_idx_r;
  assign rd_next = TOTAL_W'(rd_idx_r) + TOTAL_W'(1);

  assign mem_we = cmd.commit && (hit_r || is_new);
  assign mem_wa = hit_r ? hit_idx_r : new_idx;
  assign mem_wd = hit_r ? cnt_inc : OCC_W'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    if (cmd.lookup || cmd.rd_issue) begin
      cnt_q_r <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && is_new) begin
      lane_r[new_idx] <= elem_r;
    end
    if (cmd.capture) begin
      elem_r <= in_elem;
    end
    if (cmd.lookup) begin
      hit_r     <= hit;
      hit_idx_r <= hit_idx;
    end
    if (cmd.rd_issue) begin
      val_q_r <= lane_r[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.commit && is_new) begin
        used_r <= used_r + TOTAL_W'(1);
      end
      if (cmd.rd_emit) begin
        if (rd_next == used_r) begin
          used_r   <= '0;
          rd_idx_r <= '0;
        end else begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit || cmd.rd_emit || cmd.empty_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The three load commands never come in the same cycle.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_value_r <= elem_r;
      out_last_r  <= 1'b1;
      if (hit_r) begin
        out_kind_r  <= uvwc_pkg::KIND_POSITION;
        out_pos_r   <= uvwc_pkg::POS_W'(hit_idx_r);
        out_occ_r   <= cnt_inc;
        out_total_r <= used_r;
      end else if (full) begin
        out_kind_r  <= uvwc_pkg::KIND_OVERFLOW;
        out_pos_r   <= '0;
        out_occ_r   <= '0;
        out_total_r <= used_r;
      end else begin
        out_kind_r  <= uvwc_pkg::KIND_POSITION;
        out_pos_r   <= uvwc_pkg::POS_W'(new_idx);
        out_occ_r   <= OCC_W'(1);
        out_total_r <= used_r + TOTAL_W'(1);
      end
    end else if (cmd.rd_emit) begin
      out_kind_r  <= uvwc_pkg::KIND_ENTRY;
      out_pos_r   <= uvwc_pkg::POS_W'(rd_idx_r);
      out_value_r <= val_q_r;
      out_occ_r   <= cnt_q_r;
      out_total_r <= used_r;
      out_last_r  <= (rd_next == used_r);
    end else if (cmd.empty_emit) begin
      out_kind_r  <= uvwc_pkg::KIND_EMPTY;
      out_pos_r   <= '0;
      out_value_r <= '0;
      out_occ_r   <= '0;
      out_total_r <= '0;
      out_last_r  <= 1'b1;
    end
  end

  assign stat.used_zero = (used_r == '0);
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.rd_last   = (rd_next == used_r);

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_pos   = out_pos_r;
  assign out_value = out_value_r;
  assign out_occ   = out_occ_r;
  assign out_total = out_total_r;
  assign out_last  = out_last_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for unique_values_with_counts: a scoreboard class keeps its own
// distinct-value table and checks every output transaction against it.
// Depends on uvwc_pkg and the unique_values_with_counts RTL.
module tb_top;

  localparam int RANDOM_ITEMS = 360;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [uvwc_pkg::KIND_W-1:0]  kind;
    logic [uvwc_pkg::POS_W-1:0]   pos;
    logic [uvwc_pkg::ELEM_W-1:0]  value;
    logic [uvwc_pkg::OCC_W-1:0]   count;
    logic [uvwc_pkg::TOTAL_W-1:0] total;
    logic                         last;
  } table_result_t;

  typedef enum {SET_SMALL, SET_MID, SET_FILL, SET_NOISE} set_shape_t;
  typedef enum {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_SLOW} ready_mode_t;

  class distinct_table_sb_t;
    logic [uvwc_pkg::ELEM_W-1:0] slot_value [uvwc_pkg::CAPACITY];
    logic [uvwc_pkg::OCC_W-1:0]  slot_count [uvwc_pkg::CAPACITY];
    int                          n_distinct = 0;
    table_result_t               expected_results [$];
    int                          failures = 0;

    function void queue_expected(table_result_t r);
      expected_results.insert(expected_results.size(), r);
    endfunction

    // Works out the results of one accepted input transaction.
    function void note_item(logic op, logic [uvwc_pkg::ELEM_W-1:0] element);
      table_result_t r;
      int            hit;
      hit = -1;
      if (op == uvwc_pkg::OP_PUSH) begin
        for (int i = 0; i < n_distinct; i++)
          if (hit < 0 && slot_value[i] == element) hit = i;
        r.value = element;
        r.last  = 1'b1;
        if (hit >= 0) begin
          if (slot_count[hit] != uvwc_pkg::OCC_MAX) slot_count[hit]++;
          r.kind  = uvwc_pkg::KIND_POSITION;
          r.pos   = uvwc_pkg::POS_W'(hit);
          r.count = slot_count[hit];
          r.total = uvwc_pkg::TOTAL_W'(n_distinct);
        end else if (n_distinct >= uvwc_pkg::CAPACITY) begin
          r.kind  = uvwc_pkg::KIND_OVERFLOW;
          r.pos   = '0;
          r.count = '0;
          r.total = uvwc_pkg::TOTAL_W'(n_distinct);
        end else begin
          slot_value[n_distinct] = element;
          slot_count[n_distinct] = uvwc_pkg::OCC_W'(1);
          r.kind  = uvwc_pkg::KIND_POSITION;
          r.pos   = uvwc_pkg::POS_W'(n_distinct);
          r.count = uvwc_pkg::OCC_W'(1);
          n_distinct++;
          r.total = uvwc_pkg::TOTAL_W'(n_distinct);
        end
        queue_expected(r);
      end else if (n_distinct == 0) begin
        r = '{uvwc_pkg::KIND_EMPTY, '0, '0, '0, '0, 1'b1};
        queue_expected(r);
      end else begin
        for (int i = 0; i < n_distinct; i++) begin
          r = '{uvwc_pkg::KIND_ENTRY, uvwc_pkg::POS_W'(i), slot_value[i], slot_count[i],
                uvwc_pkg::TOTAL_W'(n_distinct), i == n_distinct - 1};
          queue_expected(r);
        end
        n_distinct = 0;
      end
    endfunction

    function bit field_differs(string name, logic [uvwc_pkg::OCC_W-1:0] exp_val,
                               logic [uvwc_pkg::OCC_W-1:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void check_result(logic [uvwc_pkg::KIND_W-1:0] kind,
                               logic [uvwc_pkg::OUT_DATA_W-1:0] data, logic last);
      table_result_t r;
      bit            bad;
      if (expected_results.size() == 0) begin
        $error("output transaction with no expected result: kind %0d data 0x%0h", kind, data);
        failures++;
        return;
      end
      r = expected_results.pop_front();
      bad = field_differs("kind", uvwc_pkg::OCC_W'(r.kind), uvwc_pkg::OCC_W'(kind));
      bad |= field_differs("position", uvwc_pkg::OCC_W'(r.pos),
                           uvwc_pkg::OCC_W'(data[uvwc_pkg::POS_W-1:0]));
      bad |= field_differs("unique_value", r.value,
                           data[uvwc_pkg::POS_W +: uvwc_pkg::ELEM_W]);
      bad |= field_differs("occurrences", r.count,
                           data[uvwc_pkg::POS_W+uvwc_pkg::ELEM_W +: uvwc_pkg::OCC_W]);
      bad |= field_differs("distinct_total", uvwc_pkg::OCC_W'(r.total),
                           uvwc_pkg::OCC_W'(data[uvwc_pkg::POS_W+uvwc_pkg::ELEM_W+uvwc_pkg::OCC_W
                                                 +: uvwc_pkg::TOTAL_W]));
      bad |= field_differs("last", uvwc_pkg::OCC_W'(r.last), uvwc_pkg::OCC_W'(last));
      if (bad) failures++;
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [31:0]                     in_tdata = '0;
  logic [0:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [uvwc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;
  logic                            out_tlast;

  distinct_table_sb_t sb = new;
  int unsigned        burst_left = 0;
  int unsigned        items_sent = 0;

  unique_values_with_counts uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #15_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_item(in_tuser[0], in_tdata);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
  end

  // The receiver switches at random between stall patterns.
  ready_mode_t ready_mode = RDY_ALWAYS;
  int unsigned ready_left = 0;
  int unsigned ready_tick = 0;

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = $urandom_range(20, 120);
    end else begin
      ready_left--;
    end
    ready_tick++;
    case (ready_mode)
      RDY_ALWAYS:   out_tready <= 1'b1;
      RDY_COIN:     out_tready <= ($urandom_range(0, 1) == 1);
      RDY_PERIODIC: out_tready <= (ready_tick % 4 != 0);
      default:      out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Presents one transaction and returns at the edge where it is accepted.
  task automatic send_item(input logic op, input logic [uvwc_pkg::ELEM_W-1:0] element);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 10);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= element;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  initial begin : stimulus
    logic [uvwc_pkg::ELEM_W-1:0] pool [64];
    logic [uvwc_pkg::ELEM_W-1:0] base;
    set_shape_t                  shape;
    int unsigned                 pool_n;
    int unsigned                 run_len;
    int unsigned                 directed_n;
    int unsigned                 set_no;

    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Finish on an empty table, repeats, the extreme values and single-bit patterns.
    send_item(uvwc_pkg::OP_FINISH, '0);
    send_item(uvwc_pkg::OP_PUSH, 32'h0000_0000);
    send_item(uvwc_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_item(uvwc_pkg::OP_PUSH, 32'h0000_0000);
    send_item(uvwc_pkg::OP_PUSH, 32'h5555_5555);
    send_item(uvwc_pkg::OP_PUSH, 32'hAAAA_AAAA);
    send_item(uvwc_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_item(uvwc_pkg::OP_PUSH, 32'h8000_0000);
    send_item(uvwc_pkg::OP_PUSH, 32'h0000_0001);
    send_item(uvwc_pkg::OP_FINISH, 32'hFFFF_FFFF);
    send_item(uvwc_pkg::OP_FINISH, '0);
    send_item(uvwc_pkg::OP_PUSH, 32'h1234_5678);
    send_item(uvwc_pkg::OP_FINISH, '0);
    directed_n = items_sent;

    set_no = 0;
    while (items_sent < directed_n + RANDOM_ITEMS) begin
      // The first set always fills the table so that overflow is reached early.
      if (set_no == 0) begin
        shape = SET_FILL;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: shape = SET_SMALL;
          5, 6:          shape = SET_MID;
          7:             shape = SET_FILL;
          default:       shape = SET_NOISE;
        endcase
      end
      set_no++;

      case (shape)
        SET_NOISE: begin
          repeat ($urandom_range(1, 10))
            send_item(($urandom_range(0, 3) == 0) ? uvwc_pkg::OP_FINISH : uvwc_pkg::OP_PUSH,
                      $urandom);
        end
        SET_FILL: begin
          // Consecutive values from a random base are all distinct.
          base = $urandom;
          pool_n = $urandom_range(uvwc_pkg::CAPACITY + 1, uvwc_pkg::CAPACITY + 8);
          for (int i = 0; i < pool_n; i++) pool[i] = base + i;
          for (int i = 0; i < pool_n; i++) send_item(uvwc_pkg::OP_PUSH, pool[i]);
          repeat ($urandom_range(2, 12))
            send_item(uvwc_pkg::OP_PUSH, pool[$urandom_range(0, pool_n - 1)]);
          send_item(uvwc_pkg::OP_FINISH, $urandom);
        end
        default: begin
          if (shape == SET_SMALL) begin
            pool_n = $urandom_range(1, 8);
            run_len = $urandom_range(1, 20);
          end else begin
            pool_n = $urandom_range(8, 24);
            run_len = $urandom_range(10, 40);
          end
          for (int i = 0; i < pool_n; i++) begin
            case ($urandom_range(0, 7))
              0:       pool[i] = $urandom_range(0, 3);
              1:       pool[i] = ~uvwc_pkg::ELEM_W'($urandom_range(0, 3));
              default: pool[i] = $urandom;
            endcase
          end
          repeat (run_len)
            send_item(uvwc_pkg::OP_PUSH, pool[$urandom_range(0, pool_n - 1)]);
          send_item(uvwc_pkg::OP_FINISH, $urandom);
        end
      endcase
    end

    in_tvalid <= 1'b0;
    // One more edge lets the monitor note the last accepted transaction.
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/uvwc_pkg.sv
hdl/uvwc_ctrl.sv
hdl/uvwc_dpath.sv
hdl/unique_values_with_counts.sv
tb/tb_top.sv
